/* design/pve_pkg.sv */
// Shared types and constants for the prefix-length varint encoder.
`timescale 1ns / 1ps

package pve_pkg;

  localparam int unsigned WordW    = 32;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned MaxBytes = 5;
  localparam int unsigned LenW     = 3;

  // Length tags in the low bits of the first byte.
  localparam logic [ByteW-1:0] Tag2    = 8'h01;
  localparam logic [ByteW-1:0] Tag3    = 8'h03;
  localparam logic [ByteW-1:0] Tag4    = 8'h07;
  localparam logic [ByteW-1:0] TagLong = 8'h0F;

  typedef enum logic {
    REQ_UNSIGNED = 1'b0,
    REQ_SIGNED   = 1'b1
  } req_type_e;

  typedef struct packed {
    logic [MaxBytes-1:0][ByteW-1:0] bytes;
    logic [LenW-1:0]                len;
  } code_t;

endpackage

/* design/pve_encode.sv */
// Length choice and byte packing for one 32-bit word.
`timescale 1ns / 1ps

module pve_encode (
  input  logic                      req_type_i,
  input  logic [pve_pkg::WordW-1:0] value_word_i,
  output pve_pkg::code_t            code_o
);
  import pve_pkg::*;

  logic [WordW-1:0] w;
  logic             fit1, fit2, fit3, fit4;

  assign w = value_word_i;

  always_comb begin
    if (req_type_i == REQ_SIGNED) begin
      // signed fits when all bits above the payload are copies of its top bit
      fit1 = (w[31:6]  == {26{w[6]}});
      fit2 = (w[31:13] == {19{w[13]}});
      fit3 = (w[31:20] == {12{w[20]}});
      fit4 = (w[31:27] == {5{w[27]}});
    end else begin
      fit1 = (w[31:7]  == '0);
      fit2 = (w[31:14] == '0);
      fit3 = (w[31:21] == '0);
      fit4 = (w[31:28] == '0);
    end
  end

  always_comb begin
    code_o.bytes = '0;
    priority if (fit1) begin
      code_o.len      = LenW'(1);
      code_o.bytes[0] = {w[6:0], 1'b0};
    end else if (fit2) begin
      code_o.len      = LenW'(2);
      code_o.bytes[0] = {w[5:0], 2'b00} | Tag2;
      code_o.bytes[1] = w[13:6];
    end else if (fit3) begin
      code_o.len      = LenW'(3);
      code_o.bytes[0] = {w[4:0], 3'b000} | Tag3;
      code_o.bytes[1] = w[12:5];
      code_o.bytes[2] = w[20:13];
    end else if (fit4) begin
      code_o.len      = LenW'(4);
      code_o.bytes[0] = {w[3:0], 4'b0000} | Tag4;
      code_o.bytes[1] = w[11:4];
      code_o.bytes[2] = w[19:12];
      code_o.bytes[3] = w[27:20];
    end else begin
      code_o.len      = LenW'(MaxBytes);
      code_o.bytes[0] = TagLong;
      code_o.bytes[1] = w[7:0];
      code_o.bytes[2] = w[15:8];
      code_o.bytes[3] = w[23:16];
      code_o.bytes[4] = w[31:24];
    end
  end

endmodule

/* design/prefix_varint_encoder.sv */
// Top level: input register, encoder, and byte-serial output register.
// Prefix-length varint encoder.
// Input channel (in_valid_i / in_ready_o) carries one 32-bit word and a
// request type per beat; output channel (out_valid_o / out_ready_i) carries
// one code byte per beat with last_byte_o on the final byte and the total
// code_length_o repeated on every byte of the word.
// A word accepted into the input register is encoded into the output
// register once that register is free; its first byte is offered from there.
// The output port moves one byte per cycle while out_ready_i is high, so a
// code holds the port for its length (1 to 5 bytes). The input register takes
// the next word while the current code is still being sent, so the next code
// is loaded as the last byte of the current one leaves.
// A stall on out_ready_i holds the current byte; while the input register
// is full, in_ready_o stays low until the last byte of the code leaves.
// Reset empties both registers; no byte is offered until a word arrives.
`timescale 1ns / 1ps

module prefix_varint_encoder (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic                      req_type_i,
  input  logic [pve_pkg::WordW-1:0] value_word_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [pve_pkg::ByteW-1:0] code_byte_o,
  output logic                      last_byte_o,
  output logic [pve_pkg::LenW-1:0]  code_length_o
);
  import pve_pkg::*;

  logic             in_valid_q;
  logic             in_type_q;
  logic [WordW-1:0] in_word_q;

  logic                           out_valid_q;
  logic [MaxBytes-1:0][ByteW-1:0] bytes_q, bytes_d;
  logic [LenW-1:0]                len_q, len_d;
  logic [LenW-1:0]                rem_q, rem_d;

  code_t enc;
  logic  last_beat, out_done, load;

  pve_encode u_encode (
    .req_type_i   (in_type_q),
    .value_word_i (in_word_q),
    .code_o       (enc)
  );

  assign last_beat  = (rem_q == LenW'(1));
  assign out_done   = out_valid_q && out_ready_i && last_beat;
  assign load       = in_valid_q && (!out_valid_q || out_done);
  assign in_ready_o = !in_valid_q || load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_type_q <= req_type_i;
      in_word_q <= value_word_i;
    end
  end

  always_comb begin
    bytes_d = bytes_q;
    len_d   = len_q;
    rem_d   = rem_q;
    if (load) begin
      bytes_d = enc.bytes;
      len_d   = enc.len;
      rem_d   = enc.len;
    end else if (out_valid_q && out_ready_i) begin
      // advance: shift the next byte down to the port
      bytes_d = {ByteW'(0), bytes_q[MaxBytes-1:1]};
      rem_d   = rem_q - LenW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      rem_q       <= '0;
    end else begin
      out_valid_q <= load || (out_valid_q && !out_done);
      rem_q       <= rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bytes_q <= bytes_d;
    len_q   <= len_d;
  end

  assign out_valid_o   = out_valid_q;
  assign code_byte_o   = bytes_q[0];
  assign last_byte_o   = last_beat;
  assign code_length_o = len_q;

  // remaining count stays within the code length while a code is held
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (rem_q != '0) && (rem_q <= len_q) && (len_q <= LenW'(MaxBytes)))
    else $error("remaining byte count out of range");

  // a non-final beat is followed by the same code with one byte fewer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_ready_i && !last_beat) |=>
      out_valid_q && (rem_q == $past(rem_q) - LenW'(1)) && $stable(len_q))
    else $error("code advanced incorrectly");

  // a code first shows with all of its bytes still to go
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> out_valid_q && (rem_q == len_q))
    else $error("new code loaded with wrong count");

  // no new word is taken while one is parked and the code is not finishing
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && out_valid_q && !out_done) |-> !in_ready_o)
    else $error("input register overwritten");

endmodule
